[rtl/core/h2r_pkg.sv]
// Shared types and constants for the HSV to RGB converter pipeline.
`default_nettype none

package h2r_pkg;

    // Field widths
    localparam int unsigned HUE_W  = 9;
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned FRAC_W = 6;
    localparam int unsigned WGT_W  = 14;
    localparam int unsigned PROD_W = CHAN_W + WGT_W;

    // Hue geometry and fixed-point scales
    localparam logic [HUE_W-1:0]  HUE_MAX    = 9'd360;
    localparam logic [HUE_W-1:0]  SECTOR_DEG = 9'd60;
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [WGT_W-1:0]  SCALE_QT   = 14'd15300;
    localparam logic [FRAC_W-1:0] FRAC_SPAN  = 6'd60;

    // x / 15300 == (x * RECIP_QT) >> RECIP_SHIFT, exact for x below 2^22
    localparam int unsigned      RECIP_W     = 24;
    localparam int unsigned      RECIP_SHIFT = 37;
    localparam logic [RECIP_W-1:0] RECIP_QT  = 24'd8982939;

    // Hue sector codes
    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYN  = 3'd2,
        SEC_CYN_BLU  = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

    // Stage 1 result: sector split
    typedef struct packed {
        t_sector            sector;
        logic [FRAC_W-1:0]  frac;
        logic [CHAN_W-1:0]  sat;
        logic [CHAN_W-1:0]  val;
    } t_s1;

    // Stage 2 result: weights for p, q, t
    typedef struct packed {
        t_sector            sector;
        logic [CHAN_W-1:0]  val;
        logic [CHAN_W-1:0]  wgt_p;
        logic [WGT_W-1:0]   wgt_q;
        logic [WGT_W-1:0]   wgt_t;
    } t_s2;

    // Stage 3 result: brightness-scaled products
    typedef struct packed {
        t_sector              sector;
        logic [CHAN_W-1:0]    val;
        logic [2*CHAN_W-1:0]  prod_p;
        logic [PROD_W-1:0]    prod_q;
        logic [PROD_W-1:0]    prod_t;
    } t_s3;

    // Stage 4 result: final channel candidates
    typedef struct packed {
        t_sector            sector;
        logic [CHAN_W-1:0]  val;
        logic [CHAN_W-1:0]  p;
        logic [CHAN_W-1:0]  q;
        logic [CHAN_W-1:0]  t;
    } t_s4;

endpackage

`default_nettype wire

[rtl/core/hsv_to_rgb_converter_unit.sv]
// Top level of the HSV to RGB converter: pipeline control and channel select.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | input     | i_valid / o_ready   | i_hue_deg, i_saturation, i_brightness
//  out     | output    | o_valid / i_ready   | o_red, o_green, o_blue
//
// Five register stages: hue split, weights, brightness products, constant
// divides, channel select. One beat per cycle while i_ready stays high.
// Each stage holds a valid bit and loads when it is empty or its successor
// loads, so a stall backs up stage by stage and bubbles are squeezed out.
// Reset clears the valid bits only.
`default_nettype none

module hsv_to_rgb_converter_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output wire logic                       o_ready,
    input  wire logic [h2r_pkg::HUE_W-1:0]  i_hue_deg,
    input  wire logic [h2r_pkg::CHAN_W-1:0] i_saturation,
    input  wire logic [h2r_pkg::CHAN_W-1:0] i_brightness,
    output wire logic                       o_valid,
    input  wire logic                       i_ready,
    output wire logic [h2r_pkg::CHAN_W-1:0] o_red,
    output wire logic [h2r_pkg::CHAN_W-1:0] o_green,
    output wire logic [h2r_pkg::CHAN_W-1:0] o_blue
);
    import h2r_pkg::*;

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] load;

    t_s1 s1;
    t_s2 s2;
    t_s3 s3;
    t_s4 s4;

    logic [CHAN_W-1:0] r_red;
    logic [CHAN_W-1:0] r_green;
    logic [CHAN_W-1:0] r_blue;
    logic [CHAN_W-1:0] n_red;
    logic [CHAN_W-1:0] n_green;
    logic [CHAN_W-1:0] n_blue;

    // Per-stage load enables, from the output side back
    always_comb begin
        load[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
    end

    // Valid bits follow the data
    always_comb begin
        n_vld = r_vld;
        if (load[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (load[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    h2r_hue u_hue (
        .i_clk        (i_clk),
        .i_en         (load[0]),
        .i_hue_deg    (i_hue_deg),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_s1         (s1)
    );

    h2r_weight u_weight (
        .i_clk (i_clk),
        .i_en  (load[1]),
        .i_s1  (s1),
        .o_s2  (s2)
    );

    h2r_mult u_mult (
        .i_clk (i_clk),
        .i_en  (load[2]),
        .i_s2  (s2),
        .o_s3  (s3)
    );

    h2r_div u_div (
        .i_clk (i_clk),
        .i_en  (load[3]),
        .i_s3  (s3),
        .o_s4  (s4)
    );

    // Sector table: route V, p, q, t onto the three channels
    always_comb begin
        unique case (s4.sector)
            SEC_RED_YEL: begin
                n_red = s4.val; n_green = s4.t;   n_blue = s4.p;
            end
            SEC_YEL_GRN: begin
                n_red = s4.q;   n_green = s4.val; n_blue = s4.p;
            end
            SEC_GRN_CYN: begin
                n_red = s4.p;   n_green = s4.val; n_blue = s4.t;
            end
            SEC_CYN_BLU: begin
                n_red = s4.p;   n_green = s4.q;   n_blue = s4.val;
            end
            SEC_BLU_MAG: begin
                n_red = s4.t;   n_green = s4.p;   n_blue = s4.val;
            end
            default: begin
                n_red = s4.val; n_green = s4.p;   n_blue = s4.q;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load[STAGES-1]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_ready = load[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

[rtl/core/h2r_hue.sv]
// Stage 1: hue clamp and split into sector and position within it.
`default_nettype none

module h2r_hue (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [h2r_pkg::HUE_W-1:0]  i_hue_deg,
    input  wire logic [h2r_pkg::CHAN_W-1:0] i_saturation,
    input  wire logic [h2r_pkg::CHAN_W-1:0] i_brightness,
    output h2r_pkg::t_s1                    o_s1
);
    import h2r_pkg::*;

    t_s1               n_s1;
    t_s1               r_s1;
    logic [HUE_W-1:0]  hue_base;

    // Compare ladder; 360 and above folds onto sector 0, position 0
    always_comb begin
        n_s1.sat = i_saturation;
        n_s1.val = i_brightness;
        if (i_hue_deg >= HUE_MAX) begin
            n_s1.sector = SEC_RED_YEL;
            hue_base    = i_hue_deg;
        end else if (i_hue_deg >= 5 * SECTOR_DEG) begin
            n_s1.sector = SEC_MAG_RED;
            hue_base    = HUE_W'(5 * SECTOR_DEG);
        end else if (i_hue_deg >= 4 * SECTOR_DEG) begin
            n_s1.sector = SEC_BLU_MAG;
            hue_base    = HUE_W'(4 * SECTOR_DEG);
        end else if (i_hue_deg >= 3 * SECTOR_DEG) begin
            n_s1.sector = SEC_CYN_BLU;
            hue_base    = HUE_W'(3 * SECTOR_DEG);
        end else if (i_hue_deg >= 2 * SECTOR_DEG) begin
            n_s1.sector = SEC_GRN_CYN;
            hue_base    = HUE_W'(2 * SECTOR_DEG);
        end else if (i_hue_deg >= SECTOR_DEG) begin
            n_s1.sector = SEC_YEL_GRN;
            hue_base    = SECTOR_DEG;
        end else begin
            n_s1.sector = SEC_RED_YEL;
            hue_base    = '0;
        end
        n_s1.frac = FRAC_W'(i_hue_deg - hue_base);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

[rtl/core/h2r_weight.sv]
// Stage 2: saturation-weighted factors for p, q and t.
`default_nettype none

module h2r_weight (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire h2r_pkg::t_s1 i_s1,
    output h2r_pkg::t_s2      o_s2
);
    import h2r_pkg::*;

    t_s2               n_s2;
    t_s2               r_s2;
    logic [WGT_W-1:0]  sat_frac;
    logic [WGT_W-1:0]  sat_rest;

    // 8x6 products, always at most 255*60 so the differences stay non-negative
    always_comb begin
        sat_frac     = WGT_W'(i_s1.sat) * WGT_W'(i_s1.frac);
        sat_rest     = WGT_W'(i_s1.sat) * WGT_W'(FRAC_SPAN - i_s1.frac);
        n_s2.sector  = i_s1.sector;
        n_s2.val     = i_s1.val;
        n_s2.wgt_p   = FULL_SCALE - i_s1.sat;
        n_s2.wgt_q   = SCALE_QT - sat_frac;
        n_s2.wgt_t   = SCALE_QT - sat_rest;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

[rtl/core/h2r_mult.sv]
// Stage 3: scale the three weights by brightness.
`default_nettype none

module h2r_mult (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire h2r_pkg::t_s2 i_s2,
    output h2r_pkg::t_s3      o_s3
);
    import h2r_pkg::*;

    t_s3 n_s3;
    t_s3 r_s3;

    // Three narrow multipliers in parallel
    always_comb begin
        n_s3.sector = i_s2.sector;
        n_s3.val    = i_s2.val;
        n_s3.prod_p = (2*CHAN_W)'(i_s2.val) * (2*CHAN_W)'(i_s2.wgt_p);
        n_s3.prod_q = PROD_W'(i_s2.val) * PROD_W'(i_s2.wgt_q);
        n_s3.prod_t = PROD_W'(i_s2.val) * PROD_W'(i_s2.wgt_t);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

`default_nettype wire

[rtl/core/h2r_div.sv]
// Stage 4: constant divides by 255 and by 15300.
`default_nettype none

module h2r_div (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire h2r_pkg::t_s3 i_s3,
    output h2r_pkg::t_s4      o_s4
);
    import h2r_pkg::*;

    localparam int unsigned MUL_W = PROD_W + RECIP_W;

    t_s4                  n_s4;
    t_s4                  r_s4;
    logic [2*CHAN_W:0]    p_sum;
    logic [MUL_W-1:0]     q_mul;
    logic [MUL_W-1:0]     t_mul;

    always_comb begin
        // x/255 = (x + (x>>8) + 1) >> 8, exact for x below 65535
        p_sum = (2*CHAN_W+1)'(i_s3.prod_p)
              + (2*CHAN_W+1)'(i_s3.prod_p >> CHAN_W)
              + (2*CHAN_W+1)'(1);
        // reciprocal multiply for /15300
        q_mul = MUL_W'(i_s3.prod_q) * MUL_W'(RECIP_QT);
        t_mul = MUL_W'(i_s3.prod_t) * MUL_W'(RECIP_QT);

        n_s4.sector = i_s3.sector;
        n_s4.val    = i_s3.val;
        n_s4.p      = p_sum[2*CHAN_W-1:CHAN_W];
        n_s4.q      = q_mul[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
        n_s4.t      = t_mul[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4 <= n_s4;
        end
    end

    assign o_s4 = r_s4;

endmodule

`default_nettype wire
